// ===== hdl/mcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpwm_pkg - shared types and constants for the multi-channel PWM pin driver
// Request and result layouts, mode codes, limits and register map.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    localparam int MCPWM_CHANNELS = 8;
    localparam int MCPWM_MAX_CHANNELS = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TICK_PRESCALE = 1'b0;

    localparam logic [7:0] PRESCALE_RST = 8'd4;
    localparam logic [7:0] DUTY_MAX     = 8'd255;
    localparam logic [7:0] COUNT_WRAP   = 8'd255;
    localparam logic [3:0] PIN_MAX      = 4'd7;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CONFIG  = 3'd1;
    localparam logic [2:0] MODE_DUTY    = 3'd2;
    localparam logic [2:0] MODE_ENABLE  = 3'd3;
    localparam logic [2:0] MODE_DISABLE = 3'd4;
    localparam logic [2:0] MODE_QUERY   = 3'd5;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] channel;
        logic [1:0] port_select;
        logic [3:0] pin_number;
        logic [9:0] duty_value;
    } t_req;

    typedef struct packed {
        logic [7:0] port1_level;
        logic [7:0] port2_level;
        logic [7:0] port3_level;
        logic [7:0] port1_used;
        logic [7:0] port2_used;
        logic [7:0] port3_used;
        logic       accepted;
        logic [7:0] duty_read;
        logic       enabled_read;
    } t_rsp;

endpackage

// ===== hdl/mcpwm_req_if.sv =====
// ----------------------------------------------------------------------------
// mcpwm_req_if - request channel
// Valid/ready channel carrying one PWM request.
// ----------------------------------------------------------------------------
interface mcpwm_req_if;
    import mcpwm_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mcpwm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mcpwm_rsp_if - result channel
// Valid/ready channel carrying one PWM result.
// ----------------------------------------------------------------------------
interface mcpwm_rsp_if;
    import mcpwm_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/multi_channel_pwm_pin_driver.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_pin_driver - multi-channel PWM generator for three ports
// Drives PWM levels onto pins of three 8-bit ports from a per-channel table.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Content
//  i_req     in         valid/ready               mode, channel, port, pin, duty
//  o_rsp     out        valid/ready               levels, masks, query data
//  APB       in         psel/penable/pready       tick_prescale at byte 0
//
//  A tick walks the channels one per cycle through the single duty
//  comparator, set by the table read port, then gives its result.
//  Every other mode steps through decode, table update and result.
//  A new request is taken once the sequencer is back in idle; a finished
//  result waits in the output register while the next request runs.
//  Reset (synchronous, active low) clears all channel tables, the ownership
//  masks and both counters, and sets the prescale to 4.
//
module multi_channel_pwm_pin_driver #(
    parameter int CHANNELS = mcpwm_pkg::MCPWM_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mcpwm_req_if.sink                         i_req,
    mcpwm_rsp_if.source                       o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcpwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcpwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcpwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import mcpwm_pkg::*;

    logic [7:0] tick_prescale;
    logic       core_valid;
    logic       core_ready;
    t_rsp       core_rsp;

    // output register: valid flag plus held result
    logic       r_rsp_valid;
    t_rsp       r_rsp;

    mcpwm_apb u_apb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_tick_prescale (tick_prescale)
    );

    mcpwm_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_prescale (tick_prescale),
        .i_req           (i_req),
        .o_rsp_valid     (core_valid),
        .i_rsp_ready     (core_ready),
        .o_rsp           (core_rsp)
    );

    // take a new result when the register is empty or being drained
    assign core_ready = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (core_ready) begin
            r_rsp_valid <= core_valid;
        end
    end

    // hold the payload while the sink stalls
    always_ff @(posedge i_clk) begin
        if (core_ready && core_valid) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

// ===== hdl/mcpwm_apb.sv =====
// ----------------------------------------------------------------------------
// mcpwm_apb - configuration register port
// Holds the tick prescale register behind an APB-style slave.
// ----------------------------------------------------------------------------
module mcpwm_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcpwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcpwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcpwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic [7:0]                        o_tick_prescale
);
    import mcpwm_pkg::*;

    logic [7:0] r_prescale;
    logic       wr_en;
    logic       sel_prescale;

    assign sel_prescale = (paddr[APB_ADDR_W-1] == REG_TICK_PRESCALE);
    assign wr_en        = psel && penable && pwrite && pready;
    assign pready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= PRESCALE_RST;
        end else if (wr_en && sel_prescale) begin
            r_prescale <= pwdata[7:0];
        end
    end

    assign prdata          = sel_prescale ? APB_DATA_W'(r_prescale) : '0;
    assign o_tick_prescale = r_prescale;

endmodule

// ===== hdl/mcpwm_core.sv =====
// ----------------------------------------------------------------------------
// mcpwm_core - channel tables and sequencer
// Walks the channels through one shared duty comparator on a tick and
// executes table updates and queries for the other modes.
// ----------------------------------------------------------------------------
module mcpwm_core #(
    parameter int CHANNELS = mcpwm_pkg::MCPWM_CHANNELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_tick_prescale,
    mcpwm_req_if.sink          i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output mcpwm_pkg::t_rsp    o_rsp
);
    import mcpwm_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0]    CH_COUNT = 5'(CHANNELS);
    localparam logic [CW-1:0] LAST_IDX = CW'(CHANNELS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    t_req                r_req;
    logic [7:0]          r_duty [CHANNELS];
    logic [7:0]          n_duty [CHANNELS];
    logic [CHANNELS-1:0] r_en, n_en;
    logic [1:0]          r_port [CHANNELS];
    logic [1:0]          n_port [CHANNELS];
    logic [2:0]          r_pin [CHANNELS];
    logic [2:0]          n_pin [CHANNELS];
    logic [2:0][7:0]     r_owned, n_owned;
    logic [2:0][7:0]     r_lv, n_lv;
    logic [7:0]          r_count, n_count;
    logic [7:0]          r_pre, n_pre;
    logic                r_acc, n_acc;
    logic [7:0]          r_dr, n_dr;
    logic                r_er, n_er;

    logic [CW-1:0] rd_idx;
    logic [7:0]    rd_duty;
    logic          rd_en;
    logic [1:0]    rd_port;
    logic [2:0]    rd_pin;
    logic          hit;
    logic [7:0]    pin_onehot;
    logic          ch_ok;
    logic          cfg_ok;
    logic [7:0]    pre_inc;
    logic [7:0]    cnt_inc;
    logic [7:0]    duty_sat;

    // single read port on the tables: scan index or addressed channel
    assign rd_idx  = (r_state == ST_SCAN) ? r_idx : r_req.channel[CW-1:0];
    assign rd_duty = r_duty[rd_idx];
    assign rd_en   = r_en[rd_idx];
    assign rd_port = r_port[rd_idx];
    assign rd_pin  = r_pin[rd_idx];

    // shared compare unit
    assign hit        = rd_en && (rd_duty > r_count) && (rd_port != 2'd0);
    assign pin_onehot = 8'd1 << rd_pin;

    assign ch_ok    = {1'b0, r_req.channel} < CH_COUNT;
    assign cfg_ok   = ch_ok && (r_req.pin_number <= PIN_MAX) && (r_req.port_select != 2'd0);
    assign pre_inc  = r_pre + 8'd1;
    assign cnt_inc  = r_count + 8'd1;
    assign duty_sat = (r_req.duty_value > 10'(DUTY_MAX)) ? DUTY_MAX : r_req.duty_value[7:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_duty  = r_duty;
        n_en    = r_en;
        n_port  = r_port;
        n_pin   = r_pin;
        n_owned = r_owned;
        n_lv    = r_lv;
        n_count = r_count;
        n_pre   = r_pre;
        n_acc   = r_acc;
        n_dr    = r_dr;
        n_er    = r_er;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_idx   = '0;
                    n_lv    = '0;
                    n_acc   = 1'b0;
                    n_dr    = 8'd0;
                    n_er    = 1'b0;
                    n_state = (i_req.payload.mode == MODE_TICK) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                for (int k = 0; k < 3; k++) begin
                    if (hit && (rd_port == 2'(k + 1))) begin
                        n_lv[k] = r_lv[k] | pin_onehot;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    // advance the shared counter once per prescale ticks
                    n_pre = pre_inc;
                    if (pre_inc >= i_tick_prescale) begin
                        n_pre   = 8'd0;
                        n_count = (cnt_inc >= COUNT_WRAP) ? 8'd0 : cnt_inc;
                    end
                    n_state = ST_RESP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_EXEC: begin
                unique case (r_req.mode)
                    MODE_CONFIG: begin
                        if (cfg_ok) begin
                            n_port[rd_idx] = r_req.port_select;
                            n_pin[rd_idx]  = r_req.pin_number[2:0];
                            for (int k = 0; k < 3; k++) begin
                                if (r_req.port_select == 2'(k + 1)) begin
                                    n_owned[k] = r_owned[k]
                                               | (8'd1 << r_req.pin_number[2:0]);
                                end
                            end
                            n_acc = 1'b1;
                        end
                    end
                    MODE_DUTY: begin
                        if (ch_ok) begin
                            n_duty[rd_idx] = duty_sat;
                        end
                    end
                    MODE_ENABLE: begin
                        if (ch_ok) begin
                            n_en[rd_idx] = 1'b1;
                        end
                    end
                    MODE_DISABLE: begin
                        if (ch_ok) begin
                            n_en[rd_idx] = 1'b0;
                        end
                    end
                    MODE_QUERY: begin
                        if (ch_ok) begin
                            n_dr = rd_duty;
                            n_er = rd_en;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_en    <= '0;
            r_owned <= '0;
            r_lv    <= '0;
            r_count <= 8'd0;
            r_pre   <= 8'd0;
            r_acc   <= 1'b0;
            r_dr    <= 8'd0;
            r_er    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_duty[c] <= 8'd0;
                r_port[c] <= 2'd0;
                r_pin[c]  <= 3'd0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_duty  <= n_duty;
            r_en    <= n_en;
            r_port  <= n_port;
            r_pin   <= n_pin;
            r_owned <= n_owned;
            r_lv    <= n_lv;
            r_count <= n_count;
            r_pre   <= n_pre;
            r_acc   <= n_acc;
            r_dr    <= n_dr;
            r_er    <= n_er;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_req.valid) begin
            r_req <= i_req.payload;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp_valid = (r_state == ST_RESP);

    always_comb begin
        o_rsp.port1_level  = r_lv[0] & r_owned[0];
        o_rsp.port2_level  = r_lv[1] & r_owned[1];
        o_rsp.port3_level  = r_lv[2] & r_owned[2];
        o_rsp.port1_used   = r_owned[0];
        o_rsp.port2_used   = r_owned[1];
        o_rsp.port3_used   = r_owned[2];
        o_rsp.accepted     = r_acc;
        o_rsp.duty_read    = r_dr;
        o_rsp.enabled_read = r_er;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != ST_IDLE))
        else $error("sequencer idle after accepting a request");

    a_owned_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_owned & $past(r_owned)) == $past(r_owned)))
        else $error("ownership mask lost a bit");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != COUNT_WRAP)
        else $error("shared counter reached wrap value");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_idx) < CHANNELS))
        else $error("scan index beyond channel count");

    a_acc_config_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RESP) && (r_req.mode != MODE_CONFIG)) |-> !r_acc)
        else $error("accepted flag set outside configure");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the multi-channel PWM pin driver
// Feeds directed and random requests (ticks, channel set-up, duty, enable,
// disable, query, unused modes) under random source gaps and sink stalls,
// across several prescale settings written over APB. A scoreboard keeps its
// own copy of the channel tables, ownership masks and counters and checks
// every result field against its prediction, in order.
// ----------------------------------------------------------------------------
import mcpwm_pkg::*;

class pwm_port_scoreboard;
    // Shadow of the block's state
    logic [7:0] duty_by_chan [MCPWM_MAX_CHANNELS];
    bit         enabled_by_chan [MCPWM_MAX_CHANNELS];
    logic [1:0] port_by_chan [MCPWM_MAX_CHANNELS];
    logic [2:0] pin_by_chan [MCPWM_MAX_CHANNELS];
    logic [7:0] owned_mask [3];
    logic [7:0] pwm_count;
    logic [7:0] tick_count;
    logic [7:0] prescale;

    t_rsp port_results_q[$];
    int   failures;
    int   results_seen;

    function new();
        for (int i = 0; i < MCPWM_MAX_CHANNELS; i++) begin
            duty_by_chan[i]    = '0;
            enabled_by_chan[i] = 1'b0;
            port_by_chan[i]    = '0;
            pin_by_chan[i]     = '0;
        end
        for (int p = 0; p < 3; p++) owned_mask[p] = '0;
        pwm_count    = '0;
        tick_count   = '0;
        prescale     = PRESCALE_RST;
        failures     = 0;
        results_seen = 0;
    endfunction

    function void set_prescale(logic [7:0] value);
        prescale = value;
    endfunction

    function int pending();
        return port_results_q.size();
    endfunction

    // Advance the shadow state by one request and return the result it gives
    function t_rsp compute_port_result(t_req r);
        t_rsp       res;
        logic [7:0] lvl [3];
        bit         chan_ok;
        res = '0;
        for (int p = 0; p < 3; p++) lvl[p] = '0;
        chan_ok = (r.channel < MCPWM_CHANNELS);
        case (r.mode)
            MODE_TICK: begin
                for (int i = 0; i < MCPWM_CHANNELS; i++) begin
                    if (enabled_by_chan[i] && duty_by_chan[i] > pwm_count &&
                        port_by_chan[i] != 2'd0)
                        lvl[port_by_chan[i] - 1][pin_by_chan[i]] = 1'b1;
                end
                for (int p = 0; p < 3; p++) lvl[p] = lvl[p] & owned_mask[p];
                tick_count = tick_count + 8'd1;
                if (tick_count >= prescale) begin
                    tick_count = '0;
                    pwm_count  = pwm_count + 8'd1;
                    if (pwm_count >= COUNT_WRAP) pwm_count = '0;
                end
            end
            MODE_CONFIG: begin
                if (chan_ok && r.pin_number <= PIN_MAX && r.port_select != 2'd0) begin
                    port_by_chan[r.channel] = r.port_select;
                    pin_by_chan[r.channel]  = r.pin_number[2:0];
                    owned_mask[r.port_select - 1][r.pin_number[2:0]] = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            MODE_DUTY: begin
                if (chan_ok)
                    duty_by_chan[r.channel] = (r.duty_value > DUTY_MAX) ?
                                              DUTY_MAX : r.duty_value[7:0];
            end
            MODE_ENABLE: begin
                if (chan_ok) enabled_by_chan[r.channel] = 1'b1;
            end
            MODE_DISABLE: begin
                if (chan_ok) enabled_by_chan[r.channel] = 1'b0;
            end
            MODE_QUERY: begin
                if (chan_ok) begin
                    res.duty_read    = duty_by_chan[r.channel];
                    res.enabled_read = enabled_by_chan[r.channel];
                end
            end
            default: ;
        endcase
        res.port1_level = lvl[0];
        res.port2_level = lvl[1];
        res.port3_level = lvl[2];
        res.port1_used  = owned_mask[0];
        res.port2_used  = owned_mask[1];
        res.port3_used  = owned_mask[2];
        return res;
    endfunction

    function void note_request(t_req r);
        port_results_q.push_back(compute_port_result(r));
    endfunction

    function string describe(t_rsp r);
        return $sformatf("lvl %02h/%02h/%02h used %02h/%02h/%02h acc %0b duty %0d en %0b",
                         r.port1_level, r.port2_level, r.port3_level,
                         r.port1_used, r.port2_used, r.port3_used,
                         r.accepted, r.duty_read, r.enabled_read);
    endfunction

    function void check_result(t_rsp got);
        t_rsp  exp;
        string bad;
        bad = "";
        results_seen++;
        if (port_results_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("result %0d arrived with nothing outstanding: %s",
                         results_seen, describe(got));
            return;
        end
        exp = port_results_q.pop_front();
        if (got.port1_level  !== exp.port1_level)  bad = {bad, " port1_level"};
        if (got.port2_level  !== exp.port2_level)  bad = {bad, " port2_level"};
        if (got.port3_level  !== exp.port3_level)  bad = {bad, " port3_level"};
        if (got.port1_used   !== exp.port1_used)   bad = {bad, " port1_used"};
        if (got.port2_used   !== exp.port2_used)   bad = {bad, " port2_used"};
        if (got.port3_used   !== exp.port3_used)   bad = {bad, " port3_used"};
        if (got.accepted     !== exp.accepted)     bad = {bad, " accepted"};
        if (got.duty_read    !== exp.duty_read)    bad = {bad, " duty_read"};
        if (got.enabled_read !== exp.enabled_read) bad = {bad, " enabled_read"};
        if (bad != "") begin
            failures++;
            if (failures <= 10) begin
                $display("result %0d differs in%s", results_seen, bad);
                $display("  expected %s", describe(exp));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction
endclass

module testbench;

    // Cycles without any request, result or register access before giving up
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mcpwm_req_if req_ch ();
    mcpwm_rsp_if rsp_ch ();

    pwm_port_scoreboard sb = new();

    int idle_cycles = 0;
    bit no_req_gaps = 1'b0;
    bit no_rsp_stalls = 1'b0;

    multi_channel_pwm_pin_driver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Hold every block input at a known value from time zero
    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
    end

    // Sample both channels at the rising edge. The result is checked before
    // the request is noted; a result can never belong to a request taken on
    // the same edge, so the order only keeps the log readable.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
                (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: hold ready low for a random stall before taking each result,
    // except through stretches where the stalls are switched off.
    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) no_rsp_stalls = ~no_rsp_stalls;
            stall = no_rsp_stalls ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Watchdog: end the run if traffic stops altogether
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Write a register through a setup and an access phase
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request after a random gap and hold it until it is taken.
    // Valid stays high into the next request when that one has no gap.
    task automatic send_request(input t_req r);
        int gap;
        if ($urandom_range(0, 39) == 0) no_req_gaps = ~no_req_gaps;
        gap = no_req_gaps ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Move to a new prescale once the block is idle
    task automatic set_prescale(input logic [7:0] value);
        drain();
        apb_write(APB_ADDR_W'(4 * REG_TICK_PRESCALE), {24'd0, value});
        sb.set_prescale(value);
    endtask

    function automatic t_req make_req(input logic [2:0] mode, input logic [3:0] channel,
                                      input logic [1:0] port, input logic [3:0] pin,
                                      input logic [9:0] duty);
        t_req r;
        r.mode        = mode;
        r.channel     = channel;
        r.port_select = port;
        r.pin_number  = pin;
        r.duty_value  = duty;
        return r;
    endfunction

    // Random request: ticks dominate so the shared counter sweeps its range,
    // channels and pins stay mostly legal so enabled pins actually toggle,
    // and duties cluster at both ends where the compare is most telling.
    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.mode = MODE_TICK;
        else if (pick < 58) r.mode = MODE_CONFIG;
        else if (pick < 70) r.mode = MODE_DUTY;
        else if (pick < 80) r.mode = MODE_ENABLE;
        else if (pick < 86) r.mode = MODE_DISABLE;
        else if (pick < 97) r.mode = MODE_QUERY;
        else                r.mode = 3'($urandom_range(6, 7));
        r.channel     = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                        : $urandom_range(8, 15));
        r.port_select = 2'(($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : 0);
        r.pin_number  = 4'(($urandom_range(0, 99) < 88) ? $urandom_range(0, 7)
                                                        : $urandom_range(8, 15));
        pick = $urandom_range(0, 99);
        if (pick < 25)      r.duty_value = 10'($urandom_range(0, 20));
        else if (pick < 50) r.duty_value = 10'($urandom_range(230, 255));
        else if (pick < 60) r.duty_value = 10'($urandom_range(256, 1023));
        else                r.duty_value = 10'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_request(random_request());
    endtask

    initial begin : stimulus
        t_req directed [$];

        // Hold reset first, then release it on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at the reset prescale of four
        directed.push_back(make_req(MODE_QUERY,   4'd0,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_TICK,    4'd0,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd0,  2'd1, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd7,  2'd3, 4'd7,  10'd0));
        // channel beyond the table, bad port, pin above seven: all rejected
        directed.push_back(make_req(MODE_CONFIG,  4'd8,  2'd2, 4'd3,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd15, 2'd3, 4'd1,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd1,  2'd0, 4'd2,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd1,  2'd2, 4'd8,  10'd0));
        directed.push_back(make_req(MODE_CONFIG,  4'd1,  2'd2, 4'd15, 10'd0));
        // saturating duty, minimum non-zero duty, ignored duty write
        directed.push_back(make_req(MODE_DUTY,    4'd0,  2'd0, 4'd0,  10'd1023));
        directed.push_back(make_req(MODE_DUTY,    4'd7,  2'd0, 4'd0,  10'd1));
        directed.push_back(make_req(MODE_DUTY,    4'd15, 2'd0, 4'd0,  10'd500));
        // channel two is enabled but never assigned a port
        directed.push_back(make_req(MODE_DUTY,    4'd2,  2'd0, 4'd0,  10'd256));
        directed.push_back(make_req(MODE_ENABLE,  4'd0,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_ENABLE,  4'd7,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_ENABLE,  4'd2,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_ENABLE,  4'd12, 2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_TICK,    4'd15, 2'd3, 4'd15, 10'd1023));
        directed.push_back(make_req(MODE_QUERY,   4'd0,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_QUERY,   4'd9,  2'd0, 4'd0,  10'd0));
        // move channel zero: its old pin keeps its ownership bit
        directed.push_back(make_req(MODE_CONFIG,  4'd0,  2'd2, 4'd5,  10'd0));
        directed.push_back(make_req(MODE_TICK,    4'd0,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_DISABLE, 4'd7,  2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(MODE_DISABLE, 4'd14, 2'd0, 4'd0,  10'd0));
        directed.push_back(make_req(3'd6,         4'd3,  2'd1, 4'd3,  10'd3));
        directed.push_back(make_req(3'd7,         4'd15, 2'd3, 4'd15, 10'd1023));
        foreach (directed[k]) send_request(directed[k]);

        // Fastest counter: enough ticks to sweep and wrap the shared count
        set_prescale(8'd1);
        random_phase(500);
        // Slowest counter
        set_prescale(8'd255);
        random_phase(150);
        // Zero behaves as one
        set_prescale(8'd0);
        random_phase(150);
        set_prescale(8'($urandom_range(2, 254)));
        random_phase(200);
        set_prescale(8'd1);
        random_phase(250);

        // Let the last result land, then wait on for any stray result
        drain();
        repeat (MCPWM_CHANNELS + 6) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
